// File: sv/swst_pkg.sv
`default_nettype none

package swst_pkg;

  typedef enum logic [1:0] {
    OP_ADD  = 2'd0,
    OP_XMIT = 2'd1,
    OP_ACK  = 2'd2,
    OP_TICK = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    KIND_SEND   = 2'd0,
    KIND_ACCEPT = 2'd1,
    KIND_REJECT = 2'd2,
    KIND_NONE   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_SCAN = 2'd1,
    ST_SEND = 2'd2,
    ST_NONE = 2'd3
  } state_e;

  localparam logic [15:0] TIMEOUT_RESET = 16'd1000;

  typedef struct packed {
    logic accept;
    logic scan;
    logic send_step;
    logic emit_none;
  } cmd_t;

  typedef struct packed {
    logic any_out;
    logic cur_out;
    logic cur_last;
    logic scan_hit;
    logic scan_end;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

// File: sv/swst_ram.sv
`default_nettype none

module swst_ram #(
  parameter int DATA_WIDTH = 32,
  parameter int DEPTH      = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [DATA_WIDTH-1:0]    wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [DATA_WIDTH-1:0]    rdata_o
);

  logic [DATA_WIDTH-1:0] mem_q [DEPTH];
  logic [DATA_WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: sv/swst_ctrl.sv
`default_nettype none

module swst_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           s_tvalid_i,
  input  wire swst_pkg::op_e  op_i,
  input  wire swst_pkg::sts_t sts_i,
  output logic                s_tready_o,
  output swst_pkg::cmd_t      cmd_o
);

  import swst_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    s_tready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_tready_o = sts_i.out_free;
        if (s_tvalid_i && sts_i.out_free) begin
          cmd_o.accept = 1'b1;
          if (op_i == OP_XMIT && sts_i.any_out) begin
            state_d = ST_SEND;
          end else if (op_i == OP_TICK) begin
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_hit) begin
          state_d = ST_SEND;
        end else if (sts_i.scan_end) begin
          state_d = ST_NONE;
        end
      end
      ST_SEND: begin
        cmd_o.send_step = sts_i.out_free;
        if (sts_i.out_free && sts_i.cur_out && sts_i.cur_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_NONE: begin
        if (sts_i.out_free) begin
          cmd_o.emit_none = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: sv/swst_dp.sv
`default_nettype none

module swst_dp #(
  parameter int WINDOW_DEPTH = 32
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire swst_pkg::cmd_t cmd_i,
  output swst_pkg::sts_t      sts_o,
  input  wire swst_pkg::op_e  op_i,
  input  wire logic [15:0]    seq_num_i,
  input  wire logic [15:0]    ack_num_i,
  input  wire logic           cfg_we_i,
  input  wire logic [15:0]    cfg_wdata_i,
  input  wire logic           m_tready_i,
  output logic                m_tvalid_o,
  output swst_pkg::kind_e     kind_o,
  output logic [15:0]         send_seq_o,
  output logic [15:0]         window_start_o,
  output logic                last_o
);

  import swst_pkg::*;

  localparam int AW = $clog2(WINDOW_DEPTH);
  localparam int CW = $clog2(WINDOW_DEPTH + 1);
  localparam logic [AW:0]   DEPTH_W = (AW+1)'(WINDOW_DEPTH);
  localparam logic [15:0]   DEPTH_16 = 16'(WINDOW_DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(WINDOW_DEPTH);
  localparam logic [AW-1:0] LAST_IDX = AW'(WINDOW_DEPTH - 1);

  logic [15:0]             base_q, base_d;
  logic [31:0]             time_q, time_d;
  logic [15:0]             tmo_q, tmo_d;
  logic [AW-1:0]           head_q, head_d;
  logic [WINDOW_DEPTH-1:0] outs_q, outs_d;
  logic [WINDOW_DEPTH-1:0] stmp_q, stmp_d;
  logic [AW-1:0]           off_q, off_d;
  logic [CW-1:0]           scan_q, scan_d;
  logic                    chk_vld_q, chk_vld_d;
  logic [AW-1:0]           chk_idx_q, chk_idx_d;
  logic                    out_vld_q, out_vld_d;
  kind_e                   kind_q;
  logic [15:0]             seq_q, ws_q;
  logic                    last_q;

  logic          emit, emit_last;
  kind_e         emit_kind;
  logic [15:0]   emit_seq, emit_ws;

  logic [15:0]   add_off, ack_off;
  logic          add_in, ack_in;
  logic [AW:0]   add_sum, cur_sum, ack_sum;
  logic [AW-1:0] add_phys, cur_phys, new_head;
  logic [AW-1:0] rel [WINDOW_DEPTH];
  logic [WINDOW_DEPTH-1:0] clr_mask;
  logic          above;
  logic [31:0]   age, rdata;
  logic          mem_we;

  assign add_off = seq_num_i - base_q;
  assign ack_off = ack_num_i - base_q;
  assign add_in  = add_off < DEPTH_16;
  assign ack_in  = ack_off < DEPTH_16;

  assign add_sum  = {1'b0, head_q} + {1'b0, add_off[AW-1:0]};
  assign add_phys = (add_sum >= DEPTH_W) ? AW'(add_sum - DEPTH_W) : add_sum[AW-1:0];
  assign cur_sum  = {1'b0, head_q} + {1'b0, off_q};
  assign cur_phys = (cur_sum >= DEPTH_W) ? AW'(cur_sum - DEPTH_W) : cur_sum[AW-1:0];
  assign ack_sum  = {1'b0, head_q} + {1'b0, ack_off[AW-1:0]} + (AW+1)'(1);
  assign new_head = (ack_sum >= DEPTH_W) ? AW'(ack_sum - DEPTH_W) : ack_sum[AW-1:0];

  // offset of each physical slot from the window start
  always_comb begin
    logic [AW:0] tmp;
    above = 1'b0;
    for (int p = 0; p < WINDOW_DEPTH; p++) begin
      tmp = (AW+1)'(p) - {1'b0, head_q};
      if (AW'(p) < head_q) begin
        tmp = tmp + DEPTH_W;
      end
      rel[p]      = tmp[AW-1:0];
      clr_mask[p] = rel[p] <= ack_off[AW-1:0];
      if (outs_q[p] && rel[p] > off_q) begin
        above = 1'b1;
      end
    end
  end

  assign age    = time_q - rdata;
  assign mem_we = cmd_i.send_step && outs_q[cur_phys];

  swst_ram #(
    .DATA_WIDTH(32),
    .DEPTH     (WINDOW_DEPTH)
  ) u_stamp_ram (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(cur_phys),
    .wdata_i(time_q),
    .raddr_i(scan_q[AW-1:0]),
    .rdata_o(rdata)
  );

  always_comb begin
    sts_o.any_out  = |outs_q;
    sts_o.cur_out  = outs_q[cur_phys];
    sts_o.cur_last = !above;
    sts_o.scan_hit = chk_vld_q && outs_q[chk_idx_q] && stmp_q[chk_idx_q]
                     && (age > {16'b0, tmo_q});
    sts_o.scan_end = chk_vld_q && (chk_idx_q == LAST_IDX);
    sts_o.out_free = !out_vld_q || m_tready_i;
  end

  always_comb begin
    base_d    = base_q;
    time_d    = time_q;
    tmo_d     = cfg_we_i ? cfg_wdata_i : tmo_q;
    head_d    = head_q;
    outs_d    = outs_q;
    stmp_d    = stmp_q;
    off_d     = off_q;
    scan_d    = scan_q;
    chk_vld_d = 1'b0;
    chk_idx_d = chk_idx_q;
    emit      = 1'b0;
    emit_kind = KIND_NONE;
    emit_seq  = 16'd0;
    emit_ws   = base_q;
    emit_last = 1'b1;

    if (cmd_i.accept) begin
      off_d  = '0;
      scan_d = '0;
      case (op_i)
        OP_ADD: begin
          emit = 1'b1;
          if (add_in) begin
            outs_d[add_phys] = 1'b1;
            emit_kind        = KIND_ACCEPT;
          end else begin
            emit_kind = KIND_REJECT;
          end
        end
        OP_ACK: begin
          emit = 1'b1;
          if (ack_in) begin
            outs_d    = outs_q & ~clr_mask;
            stmp_d    = stmp_q & ~clr_mask;
            base_d    = base_q + ack_off + 16'd1;
            head_d    = new_head;
            emit_ws   = base_d;
            emit_kind = KIND_ACCEPT;
          end else begin
            emit_kind = KIND_REJECT;
          end
        end
        OP_XMIT: begin
          if (outs_q == '0) begin
            emit = 1'b1;
          end
        end
        OP_TICK: begin
          time_d = time_q + 32'd1;
        end
        default: begin
          emit = 1'b0;
        end
      endcase
    end

    if (cmd_i.scan && scan_q < DEPTH_C) begin
      chk_vld_d = 1'b1;
      chk_idx_d = scan_q[AW-1:0];
      scan_d    = scan_q + CW'(1);
    end

    if (cmd_i.send_step) begin
      if (outs_q[cur_phys]) begin
        emit             = 1'b1;
        emit_kind        = KIND_SEND;
        emit_seq         = base_q + 16'(off_q);
        emit_last        = !above;
        stmp_d[cur_phys] = 1'b1;
      end
      off_d = off_q + AW'(1);
    end

    if (cmd_i.emit_none) begin
      emit = 1'b1;
    end

    if (emit) begin
      out_vld_d = 1'b1;
    end else if (m_tready_i) begin
      out_vld_d = 1'b0;
    end else begin
      out_vld_d = out_vld_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q    <= '0;
      time_q    <= '0;
      tmo_q     <= TIMEOUT_RESET;
      head_q    <= '0;
      outs_q    <= '0;
      stmp_q    <= '0;
      off_q     <= '0;
      scan_q    <= '0;
      chk_vld_q <= 1'b0;
      chk_idx_q <= '0;
      out_vld_q <= 1'b0;
    end else begin
      base_q    <= base_d;
      time_q    <= time_d;
      tmo_q     <= tmo_d;
      head_q    <= head_d;
      outs_q    <= outs_d;
      stmp_q    <= stmp_d;
      off_q     <= off_d;
      scan_q    <= scan_d;
      chk_vld_q <= chk_vld_d;
      chk_idx_q <= chk_idx_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      kind_q <= emit_kind;
      seq_q  <= emit_seq;
      ws_q   <= emit_ws;
      last_q <= emit_last;
    end
  end

  assign m_tvalid_o     = out_vld_q;
  assign kind_o         = kind_q;
  assign send_seq_o     = seq_q;
  assign window_start_o = ws_q;
  assign last_o         = last_q;

endmodule

`default_nettype wire

// File: sv/sliding_window_sender_tracker.sv
// Sender window bookkeeping for a go-back-N link.
// Input stream: tuser carries the operation (add, transmit, ack, tick),
// tdata carries seq_num and ack_num. Output stream: tuser carries the
// result kind, tdata carries send_seq and window_start, tlast marks the
// final result of an input item.
// cfg_we_i writes the 16-bit retransmit timeout in ticks (1000 at reset).
// Add and ack each give a single result in the cycle after the item is taken.
// Transmit walks the window one slot per cycle while the output can be loaded,
// with one send result per outstanding slot.
// Tick scans the send-time RAM one slot per cycle through its registered read
// port, then runs the transmit walk on a timeout.
// The scan reads the time RAM through its one read port; the walk writes it.
// Reset empties the window, sets the window start and the clock to zero.
// A one-entry output register holds a result while the receiver stalls; the
// walk pauses and new items are held off until that register can be loaded.
`default_nettype none

module sliding_window_sender_tracker #(
  parameter int WINDOW_DEPTH = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [31:0] s_axis_tdata_i,   // seq_num, ack_num
  input  wire logic [1:0]  s_axis_tuser_i,   // operation
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [31:0]      m_axis_tdata_o,   // send_seq, window_start
  output logic [1:0]       m_axis_tuser_o,   // kind
  output logic             m_axis_tlast_o,
  input  wire logic        cfg_we_i,
  input  wire logic [15:0] cfg_wdata_i
);

  import swst_pkg::*;

  cmd_t        cmd;
  sts_t        sts;
  op_e         op;
  kind_e       kind;
  logic [15:0] send_seq, window_start;

  assign op = op_e'(s_axis_tuser_i);

  swst_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_tvalid_i(s_axis_tvalid_i),
    .op_i      (op),
    .sts_i     (sts),
    .s_tready_o(s_axis_tready_o),
    .cmd_o     (cmd)
  );

  swst_dp #(
    .WINDOW_DEPTH(WINDOW_DEPTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .op_i          (op),
    .seq_num_i     (s_axis_tdata_i[15:0]),
    .ack_num_i     (s_axis_tdata_i[31:16]),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .m_tready_i    (m_axis_tready_i),
    .m_tvalid_o    (m_axis_tvalid_o),
    .kind_o        (kind),
    .send_seq_o    (send_seq),
    .window_start_o(window_start),
    .last_o        (m_axis_tlast_o)
  );

  assign m_axis_tuser_o = kind;
  assign m_axis_tdata_o = {window_start, send_seq};

`ifndef ASSERT_OFF
  a_single_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o != KIND_SEND) |-> m_axis_tlast_o)
    else $error("non-send result without tlast");

  a_add_ack_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o &&
     (s_axis_tuser_i == OP_ADD || s_axis_tuser_i == OP_ACK))
    |=> (m_axis_tvalid_o && m_axis_tlast_o))
    else $error("add or ack item gave no single result");

  a_ready_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o |-> (!m_axis_tvalid_o || m_axis_tready_i))
    else $error("item taken while output register is blocked");
`endif

endmodule

`default_nettype wire
